// ===== hdl/berc_pkg.sv =====
package berc_pkg;

    localparam int BUTTONS = 32;
    localparam int IDX_W = $clog2(BUTTONS);

    typedef enum logic [1:0] {
        ACT_FRAME  = 2'd0,
        ACT_TIMING = 2'd1,
        ACT_IDLE   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CFG_BUTTON_COUNT = 3'd0,
        CFG_LEFT_BASE    = 3'd1,
        CFG_RIGHT_BASE   = 3'd2,
        CFG_LEFT_PRESS   = 3'd3,
        CFG_LEFT_LET_GO  = 3'd4,
        CFG_RIGHT_PRESS  = 3'd5,
        CFG_RIGHT_LET_GO = 3'd6
    } cfg_index_t;

    localparam logic [15:0] TAN_Q16     = 16'd27146;
    localparam logic [7:0]  DELAY_RESET = 8'd30;
    localparam logic [7:0]  PULSE_RESET = 8'd1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [5:0]  base;
        logic [14:0]        press;
        logic [14:0]        letgo;
        logic               group_hit;
    } stick_req_t;

    // Bit of a direction group, dropped when it lands above bit 31.
    function automatic logic [31:0] bit_at(input logic [5:0] base, input logic [1:0] off);
        logic [5:0] p;
        p = {1'b0, base[4:0]} + {4'b0, off};
        if (base[5] || p[5])
            return 32'd0;
        else
            return 32'd1 << p[4:0];
    endfunction

    function automatic logic [31:0] group_mask(input logic [5:0] base);
        return bit_at(base, 2'd0) | bit_at(base, 2'd1) | bit_at(base, 2'd2) | bit_at(base, 2'd3);
    endfunction

endpackage

// ===== hdl/berc_stick.sv =====
module berc_stick (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  berc_pkg::stick_req_t req,
    output logic               done,
    output logic [31:0]        bits
);
    import berc_pkg::*;

    logic [2:0]  step_reg;
    logic        busy_reg;
    logic [31:0] prod_reg;
    logic [31:0] ax2_reg, len_reg, lg2_reg, pr2_reg, tax_reg, tay_reg;
    logic [15:0] ax, ay, mul_a, mul_b;
    logic        x_pos, y_pos;
    logic [31:0] up, dn, lf, rt, h_bit, v_bit;

    assign ax = req.x[15] ? (~req.x + 16'd1) : req.x;
    assign ay = req.y[15] ? (~req.y + 16'd1) : req.y;
    assign x_pos = !req.x[15] && (req.x != 16'sd0);
    assign y_pos = !req.y[15] && (req.y != 16'sd0);

    // One shared multiplier walks through the six products.
    always_comb
    begin
        case (step_reg)
            3'd0:    begin mul_a = ax;               mul_b = ax;               end
            3'd1:    begin mul_a = ay;               mul_b = ay;               end
            3'd2:    begin mul_a = {1'b0, req.letgo}; mul_b = {1'b0, req.letgo}; end
            3'd3:    begin mul_a = {1'b0, req.press}; mul_b = {1'b0, req.press}; end
            3'd4:    begin mul_a = TAN_Q16;          mul_b = ax;               end
            3'd5:    begin mul_a = TAN_Q16;          mul_b = ay;               end
            default: begin mul_a = 16'd0;            mul_b = 16'd0;            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else if (!busy_reg)
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end
        end
        else
        begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == 3'd7)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (busy_reg)
        begin
            case (step_reg)
                3'd1:    ax2_reg <= prod_reg;
                3'd2:    len_reg <= ax2_reg + prod_reg;
                3'd3:    lg2_reg <= prod_reg;
                3'd4:    pr2_reg <= prod_reg;
                3'd5:    tax_reg <= prod_reg;
                3'd6:    tay_reg <= prod_reg;
                default: ;
            endcase
        end
    end

    assign up = bit_at(req.base, 2'd0);
    assign dn = bit_at(req.base, 2'd1);
    assign lf = bit_at(req.base, 2'd2);
    assign rt = bit_at(req.base, 2'd3);
    assign h_bit = x_pos ? rt : lf;
    assign v_bit = y_pos ? up : dn;

    always_comb
    begin
        if (req.base[5])
            bits = 32'd0;
        else if (len_reg < lg2_reg)
            bits = 32'd0;
        else if (len_reg < pr2_reg && !req.group_hit)
            bits = 32'd0;
        else if (ax == 16'd0 && ay == 16'd0)
            bits = rt;
        else if ({1'b0, ay, 16'd0} < {1'b0, tax_reg})
            bits = h_bit;
        else if ({1'b0, ax, 16'd0} < {1'b0, tay_reg})
            bits = v_bit;
        else
            bits = h_bit | v_bit;
    end

    assign done = busy_reg && (step_reg == 3'd7);

endmodule

// ===== hdl/berc_rem.sv =====
module berc_rem (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic        zero
);
    import berc_pkg::*;

    logic [31:0] dvd_reg;
    logic [7:0]  div_reg, rem_reg, rem_next;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [8:0]  trial;

    // Restoring remainder, one dividend bit per cycle.
    assign trial = {rem_reg, dvd_reg[31]};
    assign rem_next = (trial >= {1'b0, div_reg}) ? 8'(trial - {1'b0, div_reg}) : trial[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= 8'd0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign zero = (rem_reg == 8'd0);

endmodule

// ===== hdl/button_edge_repeat_stick_cross.sv =====
// Pad front end: each frame transfer (action 0) folds two analog sticks into
// four direction bits each, then reports hold, press, release and autorepeat
// masks. Per-button hold counts and repeat timing live in two 32-entry
// synchronous memories that are walked one button at a time. A frame runs
// the sticks (one shared multiplier, six products per stick), then each
// button in turn, with a pass through the bit-serial remainder unit for each
// held button with a nonzero pulse whose count has reached its delay. A timing
// transfer walks the buttons; a go idle transfer goes straight to its result.
// The next transfer is taken while a result still waits.
module button_edge_repeat_stick_cross (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         action,
    input  logic [31:0]        raw_buttons,
    input  logic signed [15:0] left_x,
    input  logic signed [15:0] left_y,
    input  logic signed [15:0] right_x,
    input  logic signed [15:0] right_y,
    input  logic [31:0]        repeat_mask,
    input  logic [7:0]         repeat_delay,
    input  logic [7:0]         repeat_pulse,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [31:0]        held,
    output logic [31:0]        pressed,
    output logic [31:0]        released,
    output logic [31:0]        repeated
);
    import berc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_STICK_L = 8'b0000_0010,
        ST_STICK_R = 8'b0000_0100,
        ST_RD      = 8'b0000_1000,
        ST_EV      = 8'b0001_0000,
        ST_DIV     = 8'b0010_0000,
        ST_TIMING  = 8'b0100_0000,
        ST_FIN     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]  bc_reg;
    logic [5:0]  lbase_reg, rbase_reg;
    logic [14:0] lpress_reg, llet_reg, rpress_reg, rlet_reg;

    logic [1:0]  act_reg;
    logic [31:0] raw_reg, mask_reg;
    logic signed [15:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic [7:0]  dly_reg, pls_reg;

    logic [31:0] last_held_reg, held_reg, sticks_reg, rep_reg, c_reg;
    logic [5:0]  idx_reg;
    logic        start_reg;

    logic [31:0] cnt_mem [BUTTONS];
    logic [15:0] tim_mem [BUTTONS];
    logic [31:0] cnt_rd_reg;
    logic [15:0] tim_rd_reg;
    logic [BUTTONS-1:0] cnt_valid_reg, tim_valid_reg;

    logic [31:0] held_out_reg, pressed_reg, released_reg, repeated_reg;
    logic        result_valid_reg;

    logic [5:0]  n_lim;
    logic [BUTTONS-1:0] lim_mask;
    logic [IDX_W-1:0] addr;
    logic        item_take, out_free, out_load;
    stick_req_t  sreq;
    logic        s_done;
    logic [31:0] s_bits;
    logic        r_start, r_done, r_zero;
    logic [31:0] c_cur;
    logic [7:0]  d_cur, p_cur;
    logic        rep_due;
    logic        cnt_we;
    logic [31:0] cnt_wdata;

    assign n_lim = (bc_reg > 6'(BUTTONS)) ? 6'(BUTTONS) : bc_reg;
    assign addr = idx_reg[IDX_W-1:0];
    assign item_stall = (state_reg != ST_IDLE);
    assign item_take = item_valid && !item_stall;
    assign cfg_ready = 1'b1;
    assign out_free = !result_valid_reg || !result_stall;
    assign out_load = (state_reg == ST_FIN) && out_free;

    always_comb
    begin
        for (int i = 0; i < BUTTONS; i++)
            lim_mask[i] = (6'(i) < n_lim);
    end

    always_comb
    begin
        if (state_reg == ST_STICK_L)
        begin
            sreq.x = lx_reg; sreq.y = ly_reg; sreq.base = lbase_reg;
            sreq.press = lpress_reg; sreq.letgo = llet_reg;
        end
        else
        begin
            sreq.x = rx_reg; sreq.y = ry_reg; sreq.base = rbase_reg;
            sreq.press = rpress_reg; sreq.letgo = rlet_reg;
        end
        sreq.group_hit = |(last_held_reg & group_mask(sreq.base));
    end

    berc_stick u_stick (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .req   (sreq),
        .done  (s_done),
        .bits  (s_bits)
    );

    // Entries never written read as their reset values.
    assign c_cur = cnt_valid_reg[addr] ? cnt_rd_reg : 32'd0;
    assign d_cur = tim_valid_reg[addr] ? tim_rd_reg[15:8] : DELAY_RESET;
    assign p_cur = tim_valid_reg[addr] ? tim_rd_reg[7:0] : PULSE_RESET;
    assign rep_due = held_reg[addr] && (p_cur != 8'd0) && (c_cur >= {24'd0, d_cur});
    assign r_start = (state_reg == ST_EV) && rep_due;

    berc_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (r_start),
        .dividend (c_cur - {24'd0, d_cur}),
        .divisor  (p_cur),
        .done     (r_done),
        .zero     (r_zero)
    );

    always_comb
    begin
        cnt_we = 1'b0;
        cnt_wdata = 32'd0;
        if (state_reg == ST_EV && !rep_due)
        begin
            cnt_we = 1'b1;
            cnt_wdata = held_reg[addr] ? c_cur + 32'd1 : 32'd0;
        end
        else if (state_reg == ST_DIV && r_done)
        begin
            cnt_we = 1'b1;
            cnt_wdata = c_reg + 32'd1;
        end
    end

    // The write of entry i and the read of entry i+1 never touch the same entry.
    always_ff @(posedge clk)
    begin
        cnt_rd_reg <= cnt_mem[addr];
        tim_rd_reg <= tim_mem[addr];
        if (cnt_we)
            cnt_mem[addr] <= cnt_wdata;
        if (state_reg == ST_TIMING && idx_reg != n_lim && mask_reg[addr])
            tim_mem[addr] <= {dly_reg, pls_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (item_take)
                begin
                    case (action_t'(action))
                        ACT_FRAME:  state_next = ST_STICK_L;
                        ACT_TIMING: state_next = ST_TIMING;
                        default:    state_next = ST_FIN;
                    endcase
                end
            ST_STICK_L: if (s_done) state_next = ST_STICK_R;
            ST_STICK_R: if (s_done) state_next = ST_RD;
            ST_RD:      state_next = (idx_reg == n_lim) ? ST_FIN : ST_EV;
            ST_EV:      state_next = rep_due ? ST_DIV : ST_RD;
            ST_DIV:     if (r_done) state_next = ST_RD;
            ST_TIMING:  if (idx_reg == n_lim) state_next = ST_FIN;
            ST_FIN:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            bc_reg           <= 6'd32;
            lbase_reg        <= 6'h3F;
            rbase_reg        <= 6'h3F;
            lpress_reg       <= 15'd8192;
            llet_reg         <= 15'd4096;
            rpress_reg       <= 15'd8192;
            rlet_reg         <= 15'd4096;
            last_held_reg    <= 32'd0;
            cnt_valid_reg    <= '0;
            tim_valid_reg    <= '0;
            result_valid_reg <= 1'b0;
            start_reg        <= 1'b0;
            idx_reg          <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_BUTTON_COUNT: bc_reg     <= cfg_data[5:0];
                    CFG_LEFT_BASE:    lbase_reg  <= cfg_data[5:0];
                    CFG_RIGHT_BASE:   rbase_reg  <= cfg_data[5:0];
                    CFG_LEFT_PRESS:   lpress_reg <= cfg_data;
                    CFG_LEFT_LET_GO:  llet_reg   <= cfg_data;
                    CFG_RIGHT_PRESS:  rpress_reg <= cfg_data;
                    CFG_RIGHT_LET_GO: rlet_reg   <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == ST_IDLE && item_take)
            begin
                idx_reg <= 6'd0;
                if (action_t'(action) == ACT_FRAME)
                    start_reg <= 1'b1;
            end
            if (state_reg == ST_STICK_L && s_done)
                start_reg <= 1'b1;
            if (state_reg == ST_STICK_R && s_done)
                idx_reg <= 6'd0;
            if ((state_reg == ST_EV && !rep_due) || (state_reg == ST_DIV && r_done))
            begin
                idx_reg <= idx_reg + 6'd1;
                cnt_valid_reg[addr] <= 1'b1;
            end
            if (state_reg == ST_TIMING && idx_reg != n_lim)
            begin
                idx_reg <= idx_reg + 6'd1;
                if (mask_reg[addr])
                    tim_valid_reg[addr] <= 1'b1;
            end

            if (out_load)
            begin
                result_valid_reg <= 1'b1;
                if (action_t'(act_reg) == ACT_FRAME)
                    last_held_reg <= held_reg;
                else if (action_t'(act_reg) == ACT_IDLE)
                begin
                    last_held_reg <= 32'd0;
                    cnt_valid_reg <= cnt_valid_reg & ~lim_mask;
                end
            end
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            act_reg  <= action;
            raw_reg  <= raw_buttons;
            lx_reg   <= left_x;
            ly_reg   <= left_y;
            rx_reg   <= right_x;
            ry_reg   <= right_y;
            mask_reg <= repeat_mask;
            dly_reg  <= repeat_delay;
            pls_reg  <= repeat_pulse;
            rep_reg  <= 32'd0;
        end
        if (state_reg == ST_STICK_L && s_done)
            sticks_reg <= s_bits;
        if (state_reg == ST_STICK_R && s_done)
            held_reg <= (raw_reg & ~(group_mask(lbase_reg) | group_mask(rbase_reg)))
                        | sticks_reg | s_bits;
        if (state_reg == ST_EV)
            c_reg <= c_cur;
        if (state_reg == ST_DIV && r_done && r_zero)
            rep_reg[addr] <= 1'b1;

        if (out_load)
        begin
            case (action_t'(act_reg))
                ACT_FRAME:
                begin
                    held_out_reg <= held_reg;
                    pressed_reg  <= ~last_held_reg & held_reg;
                    released_reg <= last_held_reg & ~held_reg;
                    repeated_reg <= rep_reg;
                end
                ACT_IDLE:
                begin
                    held_out_reg <= 32'd0;
                    pressed_reg  <= 32'd0;
                    released_reg <= 32'd0;
                    repeated_reg <= 32'd0;
                end
                default:
                begin
                    held_out_reg <= last_held_reg;
                    pressed_reg  <= 32'd0;
                    released_reg <= 32'd0;
                    repeated_reg <= 32'd0;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign held     = held_out_reg;
    assign pressed  = pressed_reg;
    assign released = released_reg;
    assign repeated = repeated_reg;

    a_rem_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        r_done |-> state_reg == ST_DIV)
        else $error("remainder finished outside the repeat check");

    a_stick_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        s_done |-> (state_reg == ST_STICK_L || state_reg == ST_STICK_R))
        else $error("stick unit finished outside a stick phase");

    a_held_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> held == last_held_reg)
        else $error("reported hold mask differs from stored hold mask");

    a_rep_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((repeated & ~held) == 32'd0 && (pressed & released) == 32'd0))
        else $error("repeat or edge masks inconsistent with hold mask");

endmodule

// ===== dv/tb_button_edge_repeat_stick_cross.sv =====
module tb_button_edge_repeat_stick_cross;
    import berc_pkg::*;

    typedef struct {
        action_t            act;
        logic [31:0]        raw;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [31:0]        mask;
        logic [7:0]         delay;
        logic [7:0]         pulse;
    } frame_t;

    typedef struct {
        logic [31:0] held;
        logic [31:0] pressed;
        logic [31:0] released;
        logic [31:0] repeated;
    } masks_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [1:0]         action;
    logic [31:0]        raw_buttons;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [31:0]        repeat_mask;
    logic [7:0]         repeat_delay;
    logic [7:0]         repeat_pulse;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [14:0]        cfg_data;
    logic               result_valid;
    logic               result_stall;
    logic [31:0]        held;
    logic [31:0]        pressed;
    logic [31:0]        released;
    logic [31:0]        repeated;

    button_edge_repeat_stick_cross uut (.*);

    // Shadow of the block state and registers.
    logic [5:0]        sh_count;
    logic signed [5:0] sh_lbase;
    logic signed [5:0] sh_rbase;
    logic [14:0]       sh_lpress;
    logic [14:0]       sh_llet;
    logic [14:0]       sh_rpress;
    logic [14:0]       sh_rlet;
    logic [31:0]       sh_last;
    logic [31:0]       sh_frames [32];
    logic [7:0]        sh_delay [32];
    logic [7:0]        sh_pulse [32];

    frame_t  pending_frames[$];
    masks_t  expected_masks[$];
    int      errors;
    int      cycles;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_off;
    bit      send_pause;
    bit      taken;
    frame_t  cur;

    always #4 clk = ~clk;

    function automatic logic [31:0] dir_bit(logic signed [5:0] base, int off);
        int p;
        p = base + off;
        if (base < 0 || p > 31)
            return 32'd0;
        return 32'd1 << p;
    endfunction

    function automatic logic [31:0] dir_group(logic signed [5:0] base);
        return dir_bit(base, 0) | dir_bit(base, 1) | dir_bit(base, 2) | dir_bit(base, 3);
    endfunction

    function automatic logic [31:0] stick_dirs(logic signed [5:0] base,
                                               logic signed [15:0] x,
                                               logic signed [15:0] y,
                                               logic [14:0] press,
                                               logic [14:0] letgo,
                                               logic [31:0] prev);
        longint ax;
        longint ay;
        longint len2;
        logic [31:0] h;
        logic [31:0] v;
        ax = (x < 0) ? -longint'(x) : longint'(x);
        ay = (y < 0) ? -longint'(y) : longint'(y);
        len2 = ax * ax + ay * ay;
        if (base < 0)
            return 32'd0;
        if (len2 < longint'(letgo) * longint'(letgo))
            return 32'd0;
        if (len2 < longint'(press) * longint'(press) && (prev & dir_group(base)) == 0)
            return 32'd0;
        if (ax == 0 && ay == 0)
            return dir_bit(base, 3);
        h = (x > 0) ? dir_bit(base, 3) : dir_bit(base, 2);
        v = (y > 0) ? dir_bit(base, 0) : dir_bit(base, 1);
        if ((ay << 16) < 27146 * ax)
            return h;
        if ((ax << 16) < 27146 * ay)
            return v;
        return h | v;
    endfunction

    function automatic masks_t pad_step(frame_t f);
        masks_t r;
        int n;
        logic [31:0] prev;
        logic [31:0] hm;
        logic [31:0] c;
        n = (sh_count > 32) ? 32 : int'(sh_count);
        r = '{sh_last, 32'd0, 32'd0, 32'd0};
        case (f.act)
            ACT_TIMING:
                for (int i = 0; i < n; i++)
                    if (f.mask[i])
                    begin
                        sh_delay[i] = f.delay;
                        sh_pulse[i] = f.pulse;
                    end
            ACT_IDLE:
            begin
                for (int i = 0; i < n; i++)
                    sh_frames[i] = 0;
                sh_last = 0;
                r.held = 0;
            end
            ACT_FRAME:
            begin
                prev = sh_last;
                hm = (f.raw & ~(dir_group(sh_lbase) | dir_group(sh_rbase)))
                     | stick_dirs(sh_lbase, f.lx, f.ly, sh_lpress, sh_llet, prev)
                     | stick_dirs(sh_rbase, f.rx, f.ry, sh_rpress, sh_rlet, prev);
                for (int i = 0; i < n; i++)
                begin
                    if (hm[i])
                    begin
                        c = sh_frames[i];
                        if (sh_pulse[i] != 0)
                            if (c == sh_delay[i] ||
                                (c > sh_delay[i] && (c - sh_delay[i]) % sh_pulse[i] == 0))
                                r.repeated[i] = 1'b1;
                        sh_frames[i] = c + 1;
                    end
                    else
                        sh_frames[i] = 0;
                end
                sh_last = hm;
                r.held = hm;
                r.pressed = ~prev & hm;
                r.released = prev & ~hm;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // Driver: a transfer is predicted when it is accepted.
    always @(posedge clk)
    begin
        taken <= item_valid && !item_stall;
        if (item_valid && !item_stall)
            expected_masks.push_back(pad_step(cur));
    end

    // A new item is offered only once the previous one has been taken.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || taken))
        begin
            if (pending_frames.size() > 0 && !send_pause &&
                $urandom_range(99) >= send_idle_pct)
            begin
                cur = pending_frames.pop_front();
                item_valid <= 1'b1;
                action <= cur.act;
                raw_buttons <= cur.raw;
                left_x <= cur.lx;
                left_y <= cur.ly;
                right_x <= cur.rx;
                right_y <= cur.ry;
                repeat_mask <= cur.mask;
                repeat_delay <= cur.delay;
                repeat_pulse <= cur.pulse;
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor.
    always @(posedge clk)
    begin
        masks_t w;
        cycles <= cycles + 1;
        if (result_valid && !result_stall)
        begin
            if (expected_masks.size() == 0)
            begin
                $display("unexpected result transfer");
                errors++;
            end
            else
            begin
                w = expected_masks.pop_front();
                if (held !== w.held) report_mismatch("held", held, w.held);
                if (pressed !== w.pressed) report_mismatch("pressed", pressed, w.pressed);
                if (released !== w.released) report_mismatch("released", released, w.released);
                if (repeated !== w.repeated) report_mismatch("repeated", repeated, w.repeated);
            end
        end
        if (cycles > 4000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic cfg_write(cfg_index_t idx, logic [14:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_BUTTON_COUNT: sh_count = val[5:0];
            CFG_LEFT_BASE:    sh_lbase = val[5:0];
            CFG_RIGHT_BASE:   sh_rbase = val[5:0];
            CFG_LEFT_PRESS:   sh_lpress = val;
            CFG_LEFT_LET_GO:  sh_llet = val;
            CFG_RIGHT_PRESS:  sh_rpress = val;
            default:          sh_rlet = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_frames.size() > 0 || item_valid || expected_masks.size() > 0)
            @(posedge clk);
        repeat (1300) @(posedge clk);
    endtask

    function automatic logic signed [15:0] axis();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
        endcase
    endfunction

    function automatic frame_t rand_frame();
        frame_t f;
        int k;
        k = $urandom_range(99);
        f.act = (k < 82) ? ACT_FRAME : (k < 92) ? ACT_TIMING : (k < 97) ? ACT_IDLE : ACT_NONE;
        // Mostly keep a small set of buttons held so counts reach their delays.
        f.raw = ($urandom_range(3) == 0) ? $urandom : ($urandom & 32'h0000_00ff) | 32'h11;
        f.lx = axis();
        f.ly = axis();
        f.rx = axis();
        f.ry = axis();
        f.mask = $urandom;
        f.delay = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4));
        f.pulse = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        return f;
    endfunction

    task automatic add_frame(action_t a, logic [31:0] raw, logic signed [15:0] lx,
                             logic signed [15:0] ly, logic signed [15:0] rx,
                             logic signed [15:0] ry, logic [31:0] m, logic [7:0] d,
                             logic [7:0] p);
        pending_frames.push_back('{a, raw, lx, ly, rx, ry, m, d, p});
    endtask

    task automatic random_phase(int count);
        repeat (count) pending_frames.push_back(rand_frame());
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        item_valid = 0;
        action = ACT_FRAME;
        raw_buttons = 0;
        left_x = 0;
        left_y = 0;
        right_x = 0;
        right_y = 0;
        repeat_mask = 0;
        repeat_delay = 0;
        repeat_pulse = 0;
        cfg_valid = 0;
        cfg_index = CFG_BUTTON_COUNT;
        cfg_data = 0;
        result_stall = 0;
        errors = 0;
        cycles = 0;
        hold_off = 0;
        send_pause = 0;
        taken = 0;
        send_idle_pct = 27;
        recv_idle_pct = 63;
        sh_count = 32;
        sh_lbase = -1;
        sh_rbase = -1;
        sh_lpress = 8192;
        sh_llet = 4096;
        sh_rpress = 8192;
        sh_rlet = 4096;
        sh_last = 0;
        for (int i = 0; i < 32; i++)
        begin
            sh_frames[i] = 0;
            sh_delay[i] = DELAY_RESET;
            sh_pulse[i] = PULSE_RESET;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: sticks disabled, extremes, timings, idle and unused action.
        add_frame(ACT_FRAME, 32'hffff_ffff, 16'sd16384, 16'sd16384, -16'sd16384,
                  -16'sd16384, 0, 0, 0);
        add_frame(ACT_TIMING, 0, 0, 0, 0, 0, 32'hffff_ffff, 8'd2, 8'd3);
        add_frame(ACT_TIMING, 0, 0, 0, 0, 0, 32'h0000_000f, 8'd0, 8'd0);
        add_frame(ACT_TIMING, 0, 0, 0, 0, 0, 32'h8000_0000, 8'd255, 8'd255);
        repeat (6) add_frame(ACT_FRAME, 32'h8000_00ff, 0, 0, 0, 0, 0, 0, 0);
        add_frame(ACT_NONE, 32'hffff_ffff, 0, 0, 0, 0, 32'hffff_ffff, 8'd9, 8'd9);
        add_frame(ACT_FRAME, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
        add_frame(ACT_IDLE, 32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // Sticks enabled: left at bit 0, right near the top so bits drop off.
        cfg_write(CFG_LEFT_BASE, 15'd0);
        cfg_write(CFG_RIGHT_BASE, 15'd29);
        cfg_write(CFG_BUTTON_COUNT, 15'd63);
        add_frame(ACT_FRAME, 32'hffff_ffff, 0, 16'sd16384, 16'sd16384, 0, 0, 0, 0);
        add_frame(ACT_FRAME, 0, 16'sd6000, 16'sd0, -16'sd16384, 16'sd16384, 0, 0, 0);
        add_frame(ACT_FRAME, 0, 16'sd5000, 0, 16'sd5000, 0, 0, 0, 0);
        add_frame(ACT_FRAME, 0, 16'sd3000, 0, 16'sd3000, 0, 0, 0, 0);
        add_frame(ACT_FRAME, 0, 16'sd6000, 16'sd6000, 0, -16'sd6000, 0, 0, 0);
        add_frame(ACT_FRAME, 0, -16'sd16384, -16'sd6785, 16'sd16384, 16'sd6786, 0, 0, 0);
        drain();
        cfg_write(CFG_LEFT_PRESS, 15'd0);
        cfg_write(CFG_LEFT_LET_GO, 15'd0);
        cfg_write(CFG_RIGHT_PRESS, 15'd23170);
        cfg_write(CFG_RIGHT_LET_GO, 15'd23170);
        add_frame(ACT_FRAME, 0, 0, 0, 16'sd16384, 16'sd16384, 0, 0, 0);
        add_frame(ACT_FRAME, 0, 0, 0, 16'sd16383, 16'sd16383, 0, 0, 0);
        add_frame(ACT_FRAME, 0, 0, 0, -16'sd16384, -16'sd16384, 0, 0, 0);

        // First random phase, with a long receiver hold-off partway in.
        random_phase(150);
        while (pending_frames.size() > 75)
            @(posedge clk);
        hold_off = 3000;
        random_phase(180);
        drain();

        cfg_write(CFG_BUTTON_COUNT, 15'd0);
        cfg_write(CFG_LEFT_BASE, 15'h3f);
        cfg_write(CFG_RIGHT_BASE, 15'd28);
        cfg_write(CFG_RIGHT_PRESS, 15'd8000);
        cfg_write(CFG_RIGHT_LET_GO, 15'd9000);
        send_idle_pct = 63;
        recv_idle_pct = 27;
        random_phase(100);
        drain();

        cfg_write(CFG_BUTTON_COUNT, 15'd12);
        cfg_write(CFG_LEFT_BASE, 15'd4);
        cfg_write(CFG_LEFT_PRESS, 15'd12000);
        cfg_write(CFG_LEFT_LET_GO, 15'd4000);
        cfg_write(CFG_RIGHT_PRESS, 15'd10000);
        cfg_write(CFG_RIGHT_LET_GO, 15'd2000);
        random_phase(150);
        // Sender pause until the block is empty.
        while (pending_frames.size() > 0 || item_valid)
            @(posedge clk);
        send_pause = 1;
        while (expected_masks.size() > 0)
            @(posedge clk);
        send_pause = 0;
        random_phase(150);
        drain();

        cfg_write(CFG_BUTTON_COUNT, 15'd32);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(250);
        drain();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
